>>> sv/assert_macros.svh
// Assertion macros used by the port-level checker of the sorter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define SAT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sorter check failed");

// Antecedent implies consequent in the next cycle.
`define SAT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorter check failed");

`endif

>>> sv/sat_pkg.sv
// Shared types and constants of the stable arrival-time sorter.
package sat_pkg;

   localparam int MAX_RECORDS = 32;
   localparam int FIELD_W     = 16;

   typedef struct packed {
      logic [FIELD_W-1:0] proc_id;
      logic [FIELD_W-1:0] arrive_at;
      logic [FIELD_W-1:0] burst_length;
      logic [FIELD_W-1:0] prio_level;
   } rec_type;

   // Control broadcast to every slot of the chain
   typedef struct packed {
      logic    insert;
      logic    drain_shift;
      rec_type new_rec;
   } ctrl_type;

endpackage

>>> sv/sat_slot.sv
// One compare-and-shift slot of the insertion chain.
module sat_slot (
   input  logic              clock,
   input  logic              reset,
   input  sat_pkg::ctrl_type ctrl,
   input  sat_pkg::rec_type  left_rec,
   input  logic              left_valid,
   input  logic              left_take,
   input  sat_pkg::rec_type  right_rec,
   input  logic              right_valid,
   output sat_pkg::rec_type  slot_rec,
   output logic              slot_valid,
   output logic              slot_take
);

   sat_pkg::rec_type rec_ff, rec_in;
   logic             valid_ff, valid_in;

   // Take part in an insert when empty or holding a strictly later arrival
   assign slot_take = !valid_ff ||
                      (rec_ff.arrive_at > ctrl.new_rec.arrive_at);

   // Drain shifts towards the head; insert shifts away from it
   always_comb begin
      rec_in   = rec_ff;
      valid_in = valid_ff;
      if (ctrl.drain_shift) begin
         rec_in   = right_rec;
         valid_in = right_valid;
      end else if (ctrl.insert && slot_take) begin
         if (left_take) begin
            rec_in   = left_rec;
            valid_in = left_valid;
         end else begin
            rec_in   = ctrl.new_rec;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the record payload without reset
   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign slot_rec   = rec_ff;
   assign slot_valid = valid_ff;

endmodule

>>> sv/stable_arrival_time_sorter_top.sv
// Top level of the stable arrival-time sorter: slot chain and run control.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | id, arrival, burst, priority, last
//  rsp     | out       | rsp_valid/rsp_stall  | id, arrival, burst, priority, last, overflow
//
// Loading takes one item per cycle while req_stall is low: every slot compares and shifts at once.
// A last item starts a drain that shifts the chain one slot per taken result,
// so a run of N records gives N results, or MAX_RECORDS results when it overflowed.
// req_stall is high from the cycle after the last item until the final result is taken.
// Synchronous reset empties the chain and clears the overflow flag.
module stable_arrival_time_sorter_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_proc_id,
   input  logic [15:0] req_arrival_time,
   input  logic [15:0] req_burst_length,
   input  logic [15:0] req_prio_level,
   input  logic        req_last_record,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_out_proc_id,
   output logic [15:0] rsp_out_arrival_time,
   output logic [15:0] rsp_out_burst_length,
   output logic [15:0] rsp_out_prio_level,
   output logic        rsp_out_last,
   output logic        rsp_overflowed
);

   sat_pkg::ctrl_type                  ctrl;
   sat_pkg::rec_type                   slot_rec   [sat_pkg::MAX_RECORDS];
   logic [sat_pkg::MAX_RECORDS-1:0]    slot_valid;
   logic [sat_pkg::MAX_RECORDS-1:0]    slot_take;

   logic draining_ff, draining_in;
   logic overflow_ff, overflow_in;
   logic req_acc, rsp_acc, full, run_done;

   assign req_acc  = req_valid && !req_stall;
   assign rsp_acc  = rsp_valid && !rsp_stall;
   assign full     = slot_valid[sat_pkg::MAX_RECORDS-1];
   assign run_done = rsp_acc && rsp_out_last;

   // Broadcast control to the chain
   always_comb begin
      ctrl.insert               = req_acc && !full;
      ctrl.drain_shift          = rsp_acc;
      ctrl.new_rec.proc_id      = req_proc_id;
      ctrl.new_rec.arrive_at    = req_arrival_time;
      ctrl.new_rec.burst_length = req_burst_length;
      ctrl.new_rec.prio_level   = req_prio_level;
   end

   // Build the chain; the head slot doubles as the output register
   for (genvar i = 0; i < sat_pkg::MAX_RECORDS; i++) begin : g_slot
      sat_pkg::rec_type l_rec, r_rec;
      logic             l_valid, l_take, r_valid;
      if (i == 0) begin : g_head
         assign l_rec   = '0;
         assign l_valid = 1'b0;
         assign l_take  = 1'b0;
      end else begin : g_body
         assign l_rec   = slot_rec[i-1];
         assign l_valid = slot_valid[i-1];
         assign l_take  = slot_take[i-1];
      end
      if (i == sat_pkg::MAX_RECORDS-1) begin : g_tail
         assign r_rec   = '0;
         assign r_valid = 1'b0;
      end else begin : g_inner
         assign r_rec   = slot_rec[i+1];
         assign r_valid = slot_valid[i+1];
      end
      sat_slot u_slot (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_rec    (l_rec),
         .left_valid  (l_valid),
         .left_take   (l_take),
         .right_rec   (r_rec),
         .right_valid (r_valid),
         .slot_rec    (slot_rec[i]),
         .slot_valid  (slot_valid[i]),
         .slot_take   (slot_take[i])
      );
   end

   // Enter drain on a last item and flag an item dropped while full; clear both once the final result is taken
   always_comb begin
      draining_in = draining_ff;
      overflow_in = overflow_ff;
      if (req_acc && full) begin
         overflow_in = 1'b1;
      end
      if (req_acc && req_last_record) begin
         draining_in = 1'b1;
      end
      if (run_done) begin
         draining_in = 1'b0;
         overflow_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         draining_ff <= 1'b0;
         overflow_ff <= 1'b0;
      end else begin
         draining_ff <= draining_in;
         overflow_ff <= overflow_in;
      end
   end

   // Drive ports from the head slot and the run control flags
   assign req_stall            = draining_ff;
   assign rsp_valid            = draining_ff && slot_valid[0];
   assign rsp_out_last         = !slot_valid[1];
   assign rsp_overflowed       = overflow_ff;
   assign rsp_out_proc_id      = slot_rec[0].proc_id;
   assign rsp_out_arrival_time = slot_rec[0].arrive_at;
   assign rsp_out_burst_length = slot_rec[0].burst_length;
   assign rsp_out_prio_level   = slot_rec[0].prio_level;

endmodule

>>> sv/sat_checker.sv
// Port-level checker for the sorter, bound to the top level.
`include "assert_macros.svh"

module sat_port_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic req_last_record,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_out_last
);

   logic req_acc, rsp_acc;

   assign req_acc = req_valid && !req_stall;
   assign rsp_acc = rsp_valid && !rsp_stall;

   // A last item always opens a run of results
   `SAT_ASSERT_NEXT(a_last_starts_run, clock, reset, req_acc && req_last_record, rsp_valid)
   // No intake while results are offered
   `SAT_ASSERT_SAME(a_no_intake_in_run, clock, reset, rsp_valid, req_stall)
   // A run keeps going until its final result is taken
   `SAT_ASSERT_NEXT(a_run_continues, clock, reset, rsp_acc && !rsp_out_last, rsp_valid)
   // Nothing follows the final result of a run
   `SAT_ASSERT_NEXT(a_run_ends, clock, reset, rsp_acc && rsp_out_last, !rsp_valid)
   // A stalled result stays offered
   `SAT_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid && rsp_stall, rsp_valid)

endmodule

bind stable_arrival_time_sorter_top sat_port_checker u_sat_checker (.*);

>>> dv/sat_checker.sv
// Checker of the arrival-time sorter: predicts each sorted run and compares every result item.
module sat_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [15:0] req_proc_id,
   input  logic [15:0] req_arrival_time,
   input  logic [15:0] req_burst_length,
   input  logic [15:0] req_prio_level,
   input  logic        req_last_record,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [15:0] rsp_out_proc_id,
   input  logic [15:0] rsp_out_arrival_time,
   input  logic [15:0] rsp_out_burst_length,
   input  logic [15:0] rsp_out_prio_level,
   input  logic        rsp_out_last,
   input  logic        rsp_overflowed,
   output int          fail_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      sat_pkg::rec_type rec;
      logic             last;
      logic             ovf;
   } sorted_item_type;

   // Expected result items, oldest first
   sorted_item_type sorted_q[$];

   // Predicted contents of the record chain
   sat_pkg::rec_type held_recs [sat_pkg::MAX_RECORDS];
   int               held_count;
   bit               dropped_any;

   // Place a record after every held record with an equal or earlier arrival time
   function automatic void insert_by_arrival(input sat_pkg::rec_type r);
      int pos;
      pos = held_count;
      while (pos > 0 && held_recs[pos-1].arrive_at > r.arrive_at) begin
         held_recs[pos] = held_recs[pos-1];
         pos--;
      end
      held_recs[pos] = r;
      held_count++;
   endfunction

   // Queue the whole run in arrival order and empty the chain
   function automatic void flush_sorted_run();
      sorted_item_type item;
      for (int k = 0; k < held_count; k++) begin
         item.rec  = held_recs[k];
         item.last = (k == held_count - 1);
         item.ovf  = dropped_any;
         sorted_q  = {sorted_q, item};
      end
      held_count  = 0;
      dropped_any = 1'b0;
   endfunction

   function automatic void note_failure(input string what, input sorted_item_type exp,
                                        input sorted_item_type got);
      if (fail_count < 10) begin
         $display("%0t %s: expected id=%h arr=%h burst=%h prio=%h last=%b ovf=%b",
                  $realtime, what, exp.rec.proc_id, exp.rec.arrive_at,
                  exp.rec.burst_length, exp.rec.prio_level, exp.last, exp.ovf);
         $display("%0t %s:      got id=%h arr=%h burst=%h prio=%h last=%b ovf=%b",
                  $realtime, what, got.rec.proc_id, got.rec.arrive_at,
                  got.rec.burst_length, got.rec.prio_level, got.last, got.ovf);
      end
      fail_count++;
   endfunction

   // Watch both channels at the rising edge
   always @(posedge clock) begin : watch
      sorted_item_type  got;
      sorted_item_type  exp;
      sat_pkg::rec_type incoming;
      bit               bad;
      if (reset) begin
         sorted_q.delete();
         held_count  = 0;
         dropped_any = 1'b0;
      end else begin
         // compare a taken result item with the oldest expectation
         if (rsp_valid && !rsp_stall) begin
            got.rec.proc_id      = rsp_out_proc_id;
            got.rec.arrive_at    = rsp_out_arrival_time;
            got.rec.burst_length = rsp_out_burst_length;
            got.rec.prio_level   = rsp_out_prio_level;
            got.last             = rsp_out_last;
            got.ovf              = rsp_overflowed;
            if (sorted_q.size() == 0) begin
               exp = '0;
               note_failure("unexpected item", exp, got);
            end else begin
               exp = sorted_q.pop_front();
               bad = (got.rec.proc_id      !== exp.rec.proc_id)
                  || (got.rec.arrive_at    !== exp.rec.arrive_at)
                  || (got.rec.burst_length !== exp.rec.burst_length)
                  || (got.rec.prio_level   !== exp.rec.prio_level)
                  || (got.last             !== exp.last)
                  || (got.ovf              !== exp.ovf);
               if (bad)
                  note_failure("mismatch", exp, got);
            end
         end
         // store or drop an accepted item, and release the run on a last item
         if (req_valid && !req_stall) begin
            incoming.proc_id      = req_proc_id;
            incoming.arrive_at    = req_arrival_time;
            incoming.burst_length = req_burst_length;
            incoming.prio_level   = req_prio_level;
            if (held_count < sat_pkg::MAX_RECORDS)
               insert_by_arrival(incoming);
            else
               dropped_any = 1'b1;
            if (req_last_record)
               flush_sorted_run();
         end
      end
      pending_count = sorted_q.size();
   end

endmodule

>>> dv/stable_arrival_time_sorter_top_test.sv
// Testbench top of the arrival-time sorter: clock, reset, stimulus and verdict.
module stable_arrival_time_sorter_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [15:0] req_proc_id;
   logic [15:0] req_arrival_time;
   logic [15:0] req_burst_length;
   logic [15:0] req_prio_level;
   logic        req_last_record;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_out_proc_id;
   logic [15:0] rsp_out_arrival_time;
   logic [15:0] rsp_out_burst_length;
   logic [15:0] rsp_out_prio_level;
   logic        rsp_out_last;
   logic        rsp_overflowed;

   int fail_count;
   int pending_count;
   int items_sent;
   int set_idx;
   bit idle_on = 1'b1;

   stable_arrival_time_sorter_top u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_proc_id          (req_proc_id),
      .req_arrival_time     (req_arrival_time),
      .req_burst_length     (req_burst_length),
      .req_prio_level       (req_prio_level),
      .req_last_record      (req_last_record),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_out_proc_id      (rsp_out_proc_id),
      .rsp_out_arrival_time (rsp_out_arrival_time),
      .rsp_out_burst_length (rsp_out_burst_length),
      .rsp_out_prio_level   (rsp_out_prio_level),
      .rsp_out_last         (rsp_out_last),
      .rsp_overflowed       (rsp_overflowed)
   );

   sat_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_proc_id          (req_proc_id),
      .req_arrival_time     (req_arrival_time),
      .req_burst_length     (req_burst_length),
      .req_prio_level       (req_prio_level),
      .req_last_record      (req_last_record),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_out_proc_id      (rsp_out_proc_id),
      .rsp_out_arrival_time (rsp_out_arrival_time),
      .rsp_out_burst_length (rsp_out_burst_length),
      .rsp_out_prio_level   (rsp_out_prio_level),
      .rsp_out_last         (rsp_out_last),
      .rsp_overflowed       (rsp_overflowed),
      .fail_count           (fail_count),
      .pending_count        (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Stall the result side now and then, except in the quiet stretch
   always @(negedge clock) begin
      rsp_stall <= idle_on && ($urandom_range(99) < 9);
   end

   // Hold one item until it is taken; called at a falling edge
   task automatic send_record(input logic [15:0] id, input logic [15:0] arr,
                              input logic [15:0] burst, input logic [15:0] prio,
                              input logic last);
      while (idle_on && $urandom_range(99) < 9) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid        = 1'b1;
      req_proc_id      = id;
      req_arrival_time = arr;
      req_burst_length = burst;
      req_prio_level   = prio;
      req_last_record  = last;
      do
         @(posedge clock);
      while (req_stall);
      @(negedge clock);
      items_sent++;
   endtask

   // Send a run of random records, the final one marked last
   task automatic send_random_set(input int size);
      bit          tied;
      logic [15:0] base;
      logic [15:0] arr;
      tied = ($urandom_range(2) == 0);
      base = $urandom_range(1) ? 16'hFFF8 : 16'h0000;
      for (int k = 0; k < size; k++) begin
         arr = tied ? base + 16'($urandom_range(7)) : 16'($urandom);
         send_record(16'($urandom), arr, 16'($urandom), 16'($urandom), k == size - 1);
      end
   endtask

   // Wait until every expected item has come back
   task automatic drain_results();
      req_valid = 1'b0;
      while (pending_count != 0)
         @(negedge clock);
   endtask

   initial begin
      int size;
      int pick;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_proc_id      = '0;
      req_arrival_time = '0;
      req_burst_length = '0;
      req_prio_level   = '0;
      req_last_record  = 1'b0;
      items_sent       = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // single-record runs at both extremes
      send_record(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      send_record(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
      // equal arrival times must keep their input order
      send_record(16'h0001, 16'hFFFF, 16'h1234, 16'h0000, 1'b0);
      send_record(16'h0002, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0);
      send_record(16'h0003, 16'h8000, 16'h0000, 16'h5555, 1'b0);
      send_record(16'h0004, 16'h0000, 16'hAAAA, 16'h0001, 1'b0);
      send_record(16'h0005, 16'hFFFF, 16'h0000, 16'h8000, 1'b0);
      send_record(16'h0006, 16'h7FFF, 16'h00FF, 16'hFF00, 1'b1);
      // descending arrivals: every record goes to the front
      for (int k = 5; k >= 1; k--)
         send_record(16'(k + 16'h10), 16'(k), 16'(k * 3), 16'(k * 7), k == 1);
      // ascending arrivals: every record goes to the back
      send_record(16'h0020, 16'd10, 16'h0101, 16'h0202, 1'b0);
      send_record(16'h0021, 16'd20, 16'h0303, 16'h0404, 1'b0);
      send_record(16'h0022, 16'd30, 16'h0505, 16'h0606, 1'b1);

      // hold off until the directed runs have all come back
      drain_results();

      // random runs: a quiet stretch first, then idling on both sides
      items_sent = 0;
      set_idx    = 0;
      while (items_sent < 400) begin
         idle_on = (items_sent >= 120);
         pick    = $urandom_range(99);
         // open with a full store, a dropped last item and a wider overflow
         if (set_idx == 0)
            size = 32;
         else if (set_idx == 1)
            size = 33;
         else if (set_idx == 2)
            size = 36;
         else if (pick < 8)
            size = $urandom_range(33, 38);
         else if (pick < 14)
            size = 32;
         else if (pick < 60)
            size = $urandom_range(1, 8);
         else
            size = $urandom_range(9, 31);
         send_random_set(size);
         set_idx++;
      end
      idle_on = 1'b1;

      drain_results();
      repeat (40) @(negedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Give up after a generous fixed time
   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
